/* hdl/split_pseudo_voigt_peak_eval_unit_assert.svh */
// Assertion macros shared by the RTL.
`ifndef SPLIT_PSEUDO_VOIGT_PEAK_EVAL_UNIT_ASSERT_SVH
`define SPLIT_PSEUDO_VOIGT_PEAK_EVAL_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SPV_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define SPV_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/spv_pkg.sv */
`default_nettype none

package spv_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int ETA_ONE = 65536;
  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic [31:0] K_Q30 = 32'd2285925519;

  typedef enum logic [2:0] {
    REG_CENTER      = 3'd0,
    REG_HWHM_LEFT   = 3'd1,
    REG_HWHM_RIGHT  = 3'd2,
    REG_INTENSITY   = 3'd3,
    REG_SHAPE_LEFT  = 3'd4,
    REG_SHAPE_RIGHT = 3'd5
  } reg_index_t;

  // Q30 factor 2^(-2^-idx), built by repeated integer square roots from 0.5.
  function automatic logic [29:0] gauss_coef(input int idx);
    logic [63:0] c;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bit_v;
    int i;
    int k;
    c = 64'd1 << 29;
    for (i = 1; i <= idx; i++) begin
      v = c << 30;
      res = 64'd0;
      bit_v = 64'd1 << 62;
      for (k = 0; k < 32; k++) begin
        if (v >= res + bit_v) begin
          v = v - (res + bit_v);
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v = bit_v >> 2;
      end
      c = res;
    end
    return c[29:0];
  endfunction

endpackage

`default_nettype wire

/* hdl/spv_div.sv */
`default_nettype none

module spv_div #(
  parameter int NW = 49,
  parameter int DW = 31,
  parameter int QW = 25,
  parameter int SW = 34
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side,
  output logic          out_valid,
  output logic [QW-1:0] quot,
  output logic [SW-1:0] side_out
);

  logic [DW-1:0] rem_r  [QW];
  logic [QW-1:0] low_r  [QW];
  logic [DW-1:0] den_r  [QW];
  logic [SW-1:0] side_r [QW];
  logic [QW-1:0] vld;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [QW-1:0] low_in;
    logic [DW-1:0] den_in;
    logic [SW-1:0] side_in;
    logic          v_in;
    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] rem_next;

    if (k == 0) begin : g_first
      assign rem_in  = DW'(num >> QW);
      assign low_in  = num[QW-1:0];
      assign den_in  = den;
      assign side_in = side;
      assign v_in    = in_valid;
    end else begin : g_rest
      assign rem_in  = rem_r[k-1];
      assign low_in  = low_r[k-1];
      assign den_in  = den_r[k-1];
      assign side_in = side_r[k-1];
      assign v_in    = vld[k-1];
    end

    always_comb begin
      trial = {rem_in, low_in[QW-1]};
      ge = trial >= {1'b0, den_in};
      rem_next = ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_in;
      end
      if (en) begin
        rem_r[k]  <= rem_next;
        low_r[k]  <= {low_in[QW-2:0], ge};
        den_r[k]  <= den_in;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign quot      = low_r[QW-1];
  assign side_out  = side_r[QW-1];

endmodule

`default_nettype wire

/* hdl/spv_gauss.sv */
`default_nettype none

module spv_gauss import spv_pkg::*; #(
  parameter int F = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         en,
  input  logic [F-1:0] frac,
  input  logic [F+1:0] n,
  output logic [F:0]   g_out
);

  localparam int NB = F + 2;

  logic [30:0]   g_r [F];
  logic [F-1:0]  f_r [F];
  logic [NB-1:0] n_r [F];

  for (genvar i = 0; i < F; i++) begin : g_step
    localparam logic [29:0] COEF = gauss_coef(i + 1);
    logic [30:0]   g_in;
    logic [F-1:0]  f_in;
    logic [NB-1:0] n_in;
    logic [60:0]   prod;
    logic [60:0]   rnd;

    if (i == 0) begin : g_first
      assign g_in = 31'h4000_0000;
      assign f_in = frac;
      assign n_in = n;
    end else begin : g_rest
      assign g_in = g_r[i-1];
      assign f_in = f_r[i-1];
      assign n_in = n_r[i-1];
    end

    always_comb begin
      prod = 61'(g_in) * 61'(COEF);
      rnd = prod + (61'd1 << 29);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        g_r[i] <= f_in[F-1-i] ? rnd[60:30] : g_in;
        f_r[i] <= f_in;
        n_r[i] <= n_in;
      end
    end
  end

  logic [6:0]  s;
  logic [63:0] sh;
  logic [F:0]  g_next;

  always_comb begin
    s = 7'(n_r[F-1][5:0]) + 7'(30 - F);
    sh = (64'(g_r[F-1]) + (64'd1 << (s - 7'd1))) >> s;
    if (n_r[F-1] > NB'(40) || s > 7'd40) begin
      g_next = '0;
    end else begin
      g_next = (F+1)'(sh);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_out <= g_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/split_pseudo_voigt_peak_eval_unit.sv */
// Throughput: one word per cycle; the distance divider and the Lorentzian divider
// retire one quotient bit per stage, and the Gaussian uses one multiplier per stage.
// The whole pipeline advances whenever the output register is empty or taken.
// Reset (synchronous, active high) clears all valid bits and loads register defaults.
`default_nettype none

`include "split_pseudo_voigt_peak_eval_unit_assert.svh"

module split_pseudo_voigt_peak_eval_unit import spv_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] x_position,
  input  logic [31:0] sum_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] peak_value,
  output logic [31:0] sum_out,
  output logic [31:0] peak_area
);

  localparam int F   = FRAC_BITS;
  localparam int TW  = (3 * F + 2) / 2;
  localparam int UW  = 2 * F + 2;
  localparam int CW  = 31 + TW - F;
  localparam int MW  = 17 + F + 2;
  localparam logic [UW-1:0] U_CLAMP = UW'(1) << (2 * F + 1);

  logic [31:0] center;
  logic [30:0] hwhm_left;
  logic [30:0] hwhm_right;
  logic [31:0] intensity;
  logic [16:0] shape_left;
  logic [16:0] shape_right;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center      <= 32'd0;
      hwhm_left   <= 31'd65536;
      hwhm_right  <= 31'd65536;
      intensity   <= 32'd65536;
      shape_left  <= 17'd32768;
      shape_right <= 17'd32768;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CENTER:      center      <= cfg_data;
        REG_HWHM_LEFT:   hwhm_left   <= cfg_data[30:0];
        REG_HWHM_RIGHT:  hwhm_right  <= cfg_data[30:0];
        REG_INTENSITY:   intensity   <= cfg_data;
        REG_SHAPE_LEFT:  shape_left  <= cfg_data[16:0];
        REG_SHAPE_RIGHT: shape_right <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  logic [16:0] el;
  logic [16:0] er;
  logic [30:0] hl;
  logic [30:0] hr;
  logic [31:0] imag;
  logic        ineg;

  always_comb begin
    el = (shape_left > 17'(ETA_ONE)) ? 17'(ETA_ONE) : shape_left;
    er = (shape_right > 17'(ETA_ONE)) ? 17'(ETA_ONE) : shape_right;
    hl = (hwhm_left == 31'd0) ? 31'd1 : hwhm_left;
    hr = (hwhm_right == 31'd0) ? 31'd1 : hwhm_right;
    ineg = intensity[31];
    imag = ineg ? 32'(-intensity) : intensity;
  end

  // The area depends on the registers alone and settles after a write.
  logic [31:0] sl;
  logic [31:0] sr;
  logic [30:0] hl_a;
  logic [30:0] hr_a;
  logic [62:0] pl;
  logic [62:0] pr;
  logic [63:0] w;
  logic [31:0] imag_a;
  logic        neg_a;
  logic [63:0] p_lo;
  logic [63:0] p_hi;
  logic        neg_b;
  logic [95:0] aprod;
  logic        neg_c;
  logic [31:0] area_q;
  logic [48:0] s_l_full;
  logic [48:0] s_r_full;
  logic [95:0] amag;
  logic [95:0] alim;

  always_comb begin
    s_l_full = 49'(el) * 49'(PI_Q30) + 49'(17'(ETA_ONE) - el) * 49'(K_Q30);
    s_r_full = 49'(er) * 49'(PI_Q30) + 49'(17'(ETA_ONE) - er) * 49'(K_Q30);
    amag = (aprod + (96'd1 << (F + 30))) >> (F + 31);
    alim = neg_c ? 96'h8000_0000 : 96'h7FFF_FFFF;
    if (amag > alim) begin
      amag = alim;
    end
  end

  always_ff @(posedge clk) begin
    sl     <= s_l_full[47:16];
    sr     <= s_r_full[47:16];
    hl_a   <= hl;
    hr_a   <= hr;
    pl     <= 63'(hl_a) * 63'(sl);
    pr     <= 63'(hr_a) * 63'(sr);
    w      <= 64'(pl) + 64'(pr);
    imag_a <= imag;
    neg_a  <= ineg;
    p_lo   <= 64'(imag_a) * 64'(w[31:0]);
    p_hi   <= 64'(imag_a) * 64'(w[63:32]);
    neg_b  <= neg_a;
    aprod  <= {p_hi, 32'd0} + 96'(p_lo);
    neg_c  <= neg_b;
    area_q <= neg_c ? 32'(-amag[31:0]) : amag[31:0];
  end

  // Item pipeline.
  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  logic        v1;
  logic [31:0] x1;
  logic [31:0] sum1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      x1   <= x_position;
      sum1 <= sum_in;
    end
  end

  logic [32:0] d;
  logic        right_c;
  logic        v2;
  logic [32:0] ad2;
  logic [30:0] h2;
  logic        right2;
  logic [31:0] sum2;

  always_comb begin
    d = {x1[31], x1} - {center[31], center};
    right_c = !d[32] && (d != 33'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      ad2    <= d[32] ? 33'(-d) : d;
      h2     <= right_c ? hr : hl;
      right2 <= right_c;
      sum2   <= sum1;
    end
  end

  logic          ovf_c;
  logic          v3;
  logic [32+F:0] num3;
  logic [30:0]   den3;
  logic [33:0]   side3;

  always_comb begin
    ovf_c = CW'(ad2) >= {h2, {(TW-F){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      num3  <= ovf_c ? '0 : {ad2, {F{1'b0}}};
      den3  <= h2;
      side3 <= {sum2, right2, ovf_c};
    end
  end

  logic          vq;
  logic [TW-1:0] tq;
  logic [33:0]   sideq;

  spv_div #(.NW(33 + F), .DW(31), .QW(TW), .SW(34)) u_dist_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v3),
    .num      (num3),
    .den      (den3),
    .side     (side3),
    .out_valid(vq),
    .quot     (tq),
    .side_out (sideq)
  );

  logic          v4;
  logic [2*TW-1:0] sq4;
  logic [33:0]   side4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= vq;
    end
    if (en) begin
      sq4   <= (2*TW)'(tq) * (2*TW)'(tq);
      side4 <= sideq;
    end
  end

  logic [2*TW:0] u_c;
  logic          v5;
  logic [UW-1:0] uc5;
  logic [32:0]   side5;

  always_comb begin
    u_c = ((2*TW+1)'(sq4) + ((2*TW+1)'(1) << (F - 1))) >> F;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
    if (en) begin
      uc5   <= (side4[0] || u_c > (2*TW+1)'(U_CLAMP)) ? U_CLAMP : UW'(u_c);
      side5 <= side4[33:1];
    end
  end

  logic          v6;
  logic [UW-1:0] lden6;
  logic [UW-1:0] lnum6;
  logic [F-1:0]  frac6;
  logic [F+1:0]  n6;
  logic [32:0]   side6;
  logic [UW-1:0] lden_c;

  always_comb begin
    lden_c = (UW'(1) << F) + uc5;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
    if (en) begin
      lden6 <= lden_c;
      lnum6 <= (UW'(1) << (2 * F)) + (lden_c >> 1);
      frac6 <= uc5[F-1:0];
      n6    <= uc5[UW-1:F];
      side6 <= side5;
    end
  end

  logic         vl;
  logic [F:0]   lq;
  logic [32:0]  sidel;
  logic [F:0]   gq;

  spv_div #(.NW(UW), .DW(UW), .QW(F + 1), .SW(33)) u_lor_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v6),
    .num      (lnum6),
    .den      (lden6),
    .side     (side6),
    .out_valid(vl),
    .quot     (lq),
    .side_out (sidel)
  );

  spv_gauss #(.F(F)) u_gauss (
    .clk  (clk),
    .en   (en),
    .frac (frac6),
    .n    (n6),
    .g_out(gq)
  );

  logic [16:0]   eta_c;
  logic [MW-1:0] mix_c;
  logic          v7;
  logic [F:0]    m7;
  logic [31:0]   sum7;

  always_comb begin
    eta_c = sidel[0] ? er : el;
    mix_c = MW'(17'(ETA_ONE) - eta_c) * MW'(gq) + MW'(eta_c) * MW'(lq) + MW'(32768);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= vl;
    end
    if (en) begin
      m7   <= (F+1)'(mix_c >> 16);
      sum7 <= sidel[32:1];
    end
  end

  logic [F+32:0] mag_c;
  logic          v8;
  logic [31:0]   mag8;
  logic [31:0]   sum8;

  always_comb begin
    mag_c = ((F+33)'(imag) * (F+33)'(m7) + ((F+33)'(1) << (F - 1))) >> F;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8 <= v7;
    end
    if (en) begin
      mag8 <= mag_c[31:0];
      sum8 <= sum7;
    end
  end

  logic [31:0] value_c;
  logic [32:0] total_c;

  always_comb begin
    if (ineg) begin
      value_c = 32'(-mag8);
    end else if (mag8[31]) begin
      value_c = 32'h7FFF_FFFF;
    end else begin
      value_c = mag8;
    end
    total_c = {sum8[31], sum8} + {value_c[31], value_c};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v8;
    end
    if (en) begin
      peak_value <= value_c;
      peak_area  <= area_q;
      if (total_c[32] != total_c[31]) begin
        sum_out <= total_c[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        sum_out <= total_c[31:0];
      end
    end
  end

  `SPV_ASSERT_NOW(a_value_sign, clk, rst, out_valid && !intensity[31], !peak_value[31])
  `SPV_ASSERT_NOW(a_area_sign, clk, rst, out_valid && intensity[31],
                  peak_area[31] || peak_area == 32'd0)
  `SPV_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready,
                   out_valid && $stable(peak_value) && $stable(sum_out) && $stable(peak_area))

endmodule

`default_nettype wire

/* tb/split_pseudo_voigt_peak_eval_unit_tb.sv */
`default_nettype none

module split_pseudo_voigt_peak_eval_unit_tb;
  import spv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = 16;
  localparam int LATENCY = 3 * FB / 2 + FB + 11;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int ITEMS_PER_PHASE = 240;
  localparam int NUM_PHASES = 8;
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [31:0] value;
    logic [31:0] sum;
    logic [31:0] area;
  } peak_res_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] s;
    bit          typed;
    peak_res_t   res;
  } point_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 3'd0;
  logic [31:0] cfg_data = 32'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] x_position = 32'd0;
  logic [31:0] sum_in = 32'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] peak_value;
  logic [31:0] sum_out;
  logic [31:0] peak_area;

  // Shadow copy of the peak parameters.
  logic signed [31:0] pk_center = 32'sd0;
  logic [30:0]        pk_hwhm_l = 31'd65536;
  logic [30:0]        pk_hwhm_r = 31'd65536;
  logic signed [31:0] pk_height = 32'sd65536;
  logic [16:0]        pk_eta_l = 17'd32768;
  logic [16:0]        pk_eta_r = 17'd32768;

  logic [63:0] root_coef [1:FB];
  peak_res_t   pending_results [$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_request = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;

  split_pseudo_voigt_peak_eval_unit dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .x_position(x_position), .sum_in(sum_in),
    .out_valid(out_valid), .out_ready(out_ready), .peak_value(peak_value),
    .sum_out(sum_out), .peak_area(peak_area)
  );

  always #4 clk = ~clk;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 64'd0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] side_weight(logic [16:0] eta);
    logic [63:0] e;
    e = (eta > 17'd65536) ? 64'd65536 : 64'(eta);
    return (e * 64'(PI_Q30) + (64'd65536 - e) * 64'(K_Q30)) >> 16;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic peak_res_t eval_peak(logic [31:0] x, logic [31:0] s);
    peak_res_t   r;
    longint      dx;
    longint      val;
    bit          right_side;
    logic [63:0] h;
    logic [63:0] eta;
    logic [63:0] ad;
    logic [63:0] t;
    logic [127:0] wide;
    logic [63:0] u;
    logic [63:0] n;
    logic [63:0] g;
    logic [63:0] den;
    logic [63:0] lor;
    logic [63:0] mix;
    logic [63:0] hmag;
    logic [63:0] mag;
    logic [63:0] w;
    logic [63:0] amag;
    int          sh;
    dx = longint'($signed(x)) - longint'(pk_center);
    right_side = $signed(x) > pk_center;
    h = right_side ? 64'(pk_hwhm_r) : 64'(pk_hwhm_l);
    eta = right_side ? 64'(pk_eta_r) : 64'(pk_eta_l);
    if (h == 0) h = 1;
    if (eta > 64'd65536) eta = 64'd65536;
    ad = dx < 0 ? 64'(-dx) : 64'(dx);
    t = (ad << FB) / h;
    wide = (128'(t) * 128'(t) + (128'd1 << (FB - 1))) >> FB;
    u = (wide > (128'd1 << 62)) ? (64'd1 << 62) : wide[63:0];

    n = u >> FB;
    g = 64'd1 << 30;
    for (int i = 1; i <= FB; i++) begin
      if (u[FB - i]) g = (g * root_coef[i] + (64'd1 << 29)) >> 30;
    end
    sh = int'(n) + 30 - FB;
    if (n > 40 || sh > 40) g = 0;
    else g = (g + (64'd1 << (sh - 1))) >> sh;

    den = (64'd1 << FB) + u;
    lor = ((64'd1 << (2 * FB)) + (den >> 1)) / den;
    mix = ((64'd65536 - eta) * g + eta * lor + 64'd32768) >> 16;

    hmag = pk_height < 0 ? 64'(-longint'(pk_height)) : 64'(pk_height);
    mag = (hmag * mix + (64'd1 << (FB - 1))) >> FB;
    val = clamp32(pk_height < 0 ? -longint'(mag) : longint'(mag));
    r.value = val[31:0];
    val = clamp32(longint'($signed(s)) + val);
    r.sum = val[31:0];

    w = (pk_hwhm_l == 0 ? 64'd1 : 64'(pk_hwhm_l)) * side_weight(pk_eta_l)
      + (pk_hwhm_r == 0 ? 64'd1 : 64'(pk_hwhm_r)) * side_weight(pk_eta_r);
    wide = (128'(hmag) * 128'(w) + (128'd1 << (FB + 30))) >> (FB + 31);
    if (pk_height < 0) begin
      amag = wide > 128'd2147483648 ? 64'd2147483648 : wide[63:0];
      r.area = 32'(-longint'(amag));
    end else begin
      amag = wide > 128'd2147483647 ? 64'd2147483647 : wide[63:0];
      r.area = amag[31:0];
    end
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_CENTER:      pk_center = data;
      REG_HWHM_LEFT:   pk_hwhm_l = data[30:0];
      REG_HWHM_RIGHT:  pk_hwhm_r = data[30:0];
      REG_INTENSITY:   pk_height = data;
      REG_SHAPE_LEFT:  pk_eta_l = data[16:0];
      REG_SHAPE_RIGHT: pk_eta_r = data[16:0];
      default: ;
    endcase
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] s, bit typed, peak_res_t res);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    x_position <= x;
    sum_in <= s;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(typed ? res : eval_peak(x, s));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic setup_phase(int p);
    logic [31:0] hl;
    case (p)
      1: begin
        write_reg(REG_CENTER, 32'd0);
        write_reg(REG_HWHM_LEFT, 32'd0);
        write_reg(REG_HWHM_RIGHT, 32'hFFFF_FFFF);
        write_reg(REG_INTENSITY, 32'h8000_0000);
        write_reg(REG_SHAPE_LEFT, 32'h0001_FFFF);
        write_reg(REG_SHAPE_RIGHT, 32'd0);
        write_reg(REG_SPARE_6, 32'hDEAD_BEEF);
      end
      2: begin
        write_reg(REG_CENTER, 32'h7FFF_FFFF);
        write_reg(REG_HWHM_LEFT, 32'h7FFF_FFFF);
        write_reg(REG_HWHM_RIGHT, 32'd1);
        write_reg(REG_INTENSITY, 32'h7FFF_FFFF);
        write_reg(REG_SHAPE_LEFT, 32'd65536);
        write_reg(REG_SHAPE_RIGHT, 32'h0001_0001);
        write_reg(REG_SPARE_7, 32'h1234_5678);
      end
      3: begin
        write_reg(REG_CENTER, 32'h8000_0000);
        write_reg(REG_HWHM_LEFT, 32'h0001_0000);
        write_reg(REG_HWHM_RIGHT, 32'h0001_8000);
        write_reg(REG_INTENSITY, 32'hFFFF_0000);
        write_reg(REG_SHAPE_LEFT, 32'd0);
        write_reg(REG_SHAPE_RIGHT, 32'd65536);
      end
      default: begin
        hl = $urandom_range(0, 3) == 0 ? $urandom_range(1, 64) : $urandom_range(1, 1 << 22);
        write_reg(REG_CENTER, $urandom);
        write_reg(REG_HWHM_LEFT, hl);
        write_reg(REG_HWHM_RIGHT, $urandom_range(1, 1 << 22));
        write_reg(REG_INTENSITY, $urandom);
        write_reg(REG_SHAPE_LEFT, $urandom_range(0, 17'h1FFFF));
        write_reg(REG_SHAPE_RIGHT, $urandom_range(0, 65536));
      end
    endcase
  endtask

  function automatic logic [31:0] pick_position();
    longint span;
    longint off;
    span = 4 * longint'(pk_hwhm_l > pk_hwhm_r ? pk_hwhm_l : pk_hwhm_r) + 4;
    if (span > 64'sd2147483647) span = 64'sd2147483647;
    case ($urandom_range(0, 15))
      0: return pk_center;
      1, 2: return $urandom;
      default: begin
        off = longint'($urandom_range(0, 32'(2 * span))) - span;
        return 32'(longint'(pk_center) + off);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = 400;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(0, 99) >= stall_pct;
    end
  end

  always @(posedge clk) begin
    peak_res_t exp_res;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word value=%h sum=%h area=%h", $time, peak_value,
                 sum_out, peak_area);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        if (peak_value !== exp_res.value) begin
          $display("%0t: peak_value expected %h actual %h", $time, exp_res.value, peak_value);
          errors++;
        end
        if (sum_out !== exp_res.sum) begin
          $display("%0t: sum_out expected %h actual %h", $time, exp_res.sum, sum_out);
          errors++;
        end
        if (peak_area !== exp_res.area) begin
          $display("%0t: peak_area expected %h actual %h", $time, exp_res.area, peak_area);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("split_pseudo_voigt_peak_eval_unit_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    point_row_t rows [$];
    peak_res_t  none;
    logic [63:0] c;
    int mode;
    none = '0;
    c = 64'd1 << 29;
    for (int i = 1; i <= FB; i++) begin
      c = int_sqrt(c << 30);
      root_coef[i] = c;
    end

    rows.push_back('{32'd0, 32'd0, 1'b1, '{32'd65536, 32'd65536, 32'd172705}});
    rows.push_back('{32'd0, 32'h7FFF_FFFF, 1'b1, '{32'd65536, 32'h7FFF_FFFF, 32'd172705}});
    rows.push_back('{32'd0, 32'h8000_0000, 1'b1, '{32'd65536, 32'h8001_0000, 32'd172705}});
    rows.push_back('{32'h7FFF_FFFF, 32'd0, 1'b1, '{32'd0, 32'd0, 32'd172705}});
    rows.push_back('{32'h8000_0000, 32'd0, 1'b1, '{32'd0, 32'd0, 32'd172705}});
    rows.push_back('{32'd1, 32'd5, 1'b0, none});
    rows.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, none});
    rows.push_back('{32'h0001_0000, 32'd0, 1'b0, none});
    rows.push_back('{32'hFFFF_0000, 32'd0, 1'b0, none});
    rows.push_back('{32'h0002_0000, 32'hAAAA_AAAA, 1'b0, none});
    rows.push_back('{32'h0000_8000, 32'h5555_5555, 1'b0, none});
    rows.push_back('{32'h0030_0000, 32'h7FFF_0000, 1'b0, none});
    rows.push_back('{32'hFFF9_0000, 32'h8000_0001, 1'b0, none});
    rows.push_back('{32'h0000_B505, 32'h0000_FFFF, 1'b0, none});

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send_point(rows[i].x, rows[i].s, rows[i].typed, rows[i].res);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      mode = p % 4;
      send_idle_pct = (mode == 1) ? 79 : (mode == 3) ? 31 : 0;
      stall_pct = (mode == 2) ? 79 : (mode == 3) ? 31 : 0;
      if (p > 0) setup_phase(p);
      if (p == 4) hold_request = 1;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) send_point(pick_position(), $urandom, 1'b0, none);
      drain();
    end

    if (errors == 0) begin
      $display("split_pseudo_voigt_peak_eval_unit_tb OK");
    end else begin
      $display("split_pseudo_voigt_peak_eval_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
